FILE: design/btff_pkg.sv
// ----------------------------------------------------------------------------
// btff_pkg: shared types and constants of the first-fit block allocator
// Request kinds, the sequencer state type and the payload structs.
// ----------------------------------------------------------------------------
`default_nettype none
package btff_pkg;

  // request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INFO  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] request_size;
    logic [11:0] user_address;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] granted_address;
    logic [10:0] busy_blocks;
    logic [12:0] bytes_in_use;
    logic [12:0] largest_free;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_INIT,      // write the reset tags
    ST_INIT2,
    ST_IDLE,
    ST_RD,        // issue read of tag at p
    ST_EVAL,      // tag data valid
    ST_SPLIT_A,   // write tags of alloc split / take
    ST_SPLIT_B,
    ST_SPLIT_C,
    ST_SPLIT_D,
    ST_FREE_A,    // mark freed block head
    ST_FREE_B,    // mark freed block foot
    ST_MR_RD,     // read right neighbour head
    ST_MR_EV,
    ST_MR_W1,
    ST_MR_W2,
    ST_ML_RD,     // read left neighbour foot
    ST_ML_EV,
    ST_ML_W1,
    ST_ML_W2,
    ST_DONE
  } state_t;

  // memory command from the sequencer
  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [63:0] wdata;
  } mem_cmd_t;

endpackage
`default_nettype wire

FILE: design/btff_if.sv
// ----------------------------------------------------------------------------
// btff_if: valid/ready channel
// Carries one payload item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface btff_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/btff_tag_ram.sv
// ----------------------------------------------------------------------------
// btff_tag_ram: tag store
// One word per tag slot; a tag at byte position p lives at word p.
// Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none
module btff_tag_ram #(
  parameter int DEPTH = 4096,
  parameter int TW    = 16,
  parameter int AW    = 12
) (
  input  wire logic                clk,
  input  wire btff_pkg::mem_cmd_t  cmd,
  output logic [TW-1:0]            rdata
);
  logic [TW-1:0] mem [DEPTH];

  // write, or read with registered data
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.addr[AW-1:0]] <= cmd.wdata[TW-1:0];
    end
    rdata <= mem[cmd.addr[AW-1:0]];
  end
endmodule
`default_nettype wire

FILE: design/boundary_tag_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator: first-fit allocator with boundary tags
// Walks the block chain in a tag memory to allocate, free and report.
// ----------------------------------------------------------------------------
// channel | dir | fields
// in      | in  | kind, request_size, user_address
// out     | out | ok, granted_address, busy_blocks, bytes_in_use, largest_free
//
// One item at a time, taken in the idle step. The walk visits each block with a tag
// read step, then an evaluate step; an allocate adds the split steps A to D, writing up
// to four tags, a free adds up to ten steps for the release and both merges, and a done
// step posts the result to the output register. The single-port tag memory sets this.
// After reset the INIT and INIT2 steps write the initial tags before in_ready rises.
// The result waits in an output register; in_ready rises the cycle after it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module boundary_tag_first_fit_allocator #(
  parameter int ARENA_BYTES = 4096,
  parameter int TAG_BYTES   = 2
) (
  input wire logic clk,
  input wire logic rst_n,
  btff_if.sink    in_ch,
  btff_if.source  out_ch
);
  localparam int TW = 8 * TAG_BYTES;
  localparam int AW = $clog2(ARENA_BYTES);
  localparam int PW = AW + 2;
  localparam logic [PW-1:0] ARENA = PW'(ARENA_BYTES);
  localparam logic [PW-1:0] TB    = PW'(TAG_BYTES);
  localparam logic [PW-1:0] TB2   = PW'(2 * TAG_BYTES);
  localparam logic [PW-1:0] MINSP = PW'(2 * TAG_BYTES + 1);

  btff_pkg::state_t st_r, st_nxt;
  btff_pkg::req_t   req_r;
  btff_pkg::rsp_t   rsp_r;
  logic             ovalid_r;
  logic [PW-1:0]    p_r, p_nxt;
  logic [PW-1:0]    sz_r, sz_nxt;     // size held across steps
  logic [PW-1:0]    aux_r, aux_nxt;   // neighbour head position
  logic [10:0]      busy_r;
  logic [12:0]      used_r;
  logic [12:0]      largest_r;
  btff_pkg::mem_cmd_t cmd;
  logic [TW-1:0]    rdata;

  logic [PW-1:0] tsize, tnext;
  logic          tfree;
  logic          in_fire;

  btff_tag_ram #(.DEPTH(ARENA_BYTES), .TW(TW), .AW(AW)) u_ram (
    .clk(clk), .cmd(cmd), .rdata(rdata)
  );

  assign tsize = PW'(rdata >> 1);
  assign tfree = rdata[0];
  assign tnext = p_r + tsize + TB2;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == btff_pkg::ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = rsp_r;

  function automatic logic [63:0] tagv(input logic [PW-1:0] s, input logic f);
    logic [63:0] v;
    v = {{(64 - PW){1'b0}}, s};
    tagv = {v[62:0], f};
  endfunction

  // next state and sequencing registers
  always_comb begin
    st_nxt = st_r;
    p_nxt = p_r;
    sz_nxt = sz_r;
    aux_nxt = aux_r;
    case (st_r)
      btff_pkg::ST_INIT:  st_nxt = btff_pkg::ST_INIT2;
      btff_pkg::ST_INIT2: st_nxt = btff_pkg::ST_IDLE;
      btff_pkg::ST_IDLE: begin
        if (in_fire) begin
          p_nxt = '0;
          st_nxt = (in_ch.data.kind inside {btff_pkg::KIND_ALLOC, btff_pkg::KIND_FREE,
                                            btff_pkg::KIND_INFO})
                   ? btff_pkg::ST_RD : btff_pkg::ST_DONE;
        end
      end
      btff_pkg::ST_RD: st_nxt = (p_r + TB > ARENA) ? btff_pkg::ST_DONE : btff_pkg::ST_EVAL;
      btff_pkg::ST_EVAL: begin
        sz_nxt = tsize;
        if (tnext > ARENA) begin
          st_nxt = btff_pkg::ST_DONE;
        end else begin
          case (req_r.kind)
            btff_pkg::KIND_ALLOC: begin
              if (tfree && PW'(req_r.request_size) <= tsize) st_nxt = btff_pkg::ST_SPLIT_A;
              else begin
                p_nxt = tnext;
                st_nxt = (tnext < ARENA) ? btff_pkg::ST_RD : btff_pkg::ST_DONE;
              end
            end
            btff_pkg::KIND_FREE: begin
              if (p_r + TB == PW'(req_r.user_address)) begin
                st_nxt = tfree ? btff_pkg::ST_DONE : btff_pkg::ST_FREE_A;
              end else if (p_r + TB > PW'(req_r.user_address)) begin
                st_nxt = btff_pkg::ST_DONE;
              end else begin
                p_nxt = tnext;
                st_nxt = (tnext < ARENA) ? btff_pkg::ST_RD : btff_pkg::ST_DONE;
              end
            end
            default: begin
              p_nxt = tnext;
              st_nxt = (tnext < ARENA) ? btff_pkg::ST_RD : btff_pkg::ST_DONE;
            end
          endcase
        end
      end
      btff_pkg::ST_SPLIT_A: st_nxt = btff_pkg::ST_SPLIT_B;
      btff_pkg::ST_SPLIT_B: st_nxt = btff_pkg::ST_SPLIT_C;
      btff_pkg::ST_SPLIT_C: st_nxt = btff_pkg::ST_SPLIT_D;
      btff_pkg::ST_SPLIT_D: st_nxt = btff_pkg::ST_DONE;
      btff_pkg::ST_FREE_A:  st_nxt = btff_pkg::ST_FREE_B;
      btff_pkg::ST_FREE_B: begin
        aux_nxt = p_r + sz_r + TB2;
        st_nxt = (p_r + sz_r + TB2 >= ARENA) ? btff_pkg::ST_ML_RD : btff_pkg::ST_MR_RD;
      end
      btff_pkg::ST_MR_RD:
        st_nxt = (aux_r + TB > ARENA) ? btff_pkg::ST_ML_RD : btff_pkg::ST_MR_EV;
      btff_pkg::ST_MR_EV: begin
        if (tfree) begin
          sz_nxt = sz_r + tsize + TB2;
          st_nxt = btff_pkg::ST_MR_W1;
        end else st_nxt = btff_pkg::ST_ML_RD;
      end
      btff_pkg::ST_MR_W1: st_nxt = btff_pkg::ST_MR_W2;
      btff_pkg::ST_MR_W2: st_nxt = btff_pkg::ST_ML_RD;
      btff_pkg::ST_ML_RD:
        st_nxt = (p_r < TB2) ? btff_pkg::ST_DONE : btff_pkg::ST_ML_EV;
      btff_pkg::ST_ML_EV: begin
        if (tfree && tsize + TB2 <= p_r) begin
          aux_nxt = p_r - TB2 - tsize;
          sz_nxt = tsize + sz_r + TB2;
          st_nxt = btff_pkg::ST_ML_W1;
        end else st_nxt = btff_pkg::ST_DONE;
      end
      btff_pkg::ST_ML_W1: st_nxt = btff_pkg::ST_ML_W2;
      btff_pkg::ST_ML_W2: st_nxt = btff_pkg::ST_DONE;
      btff_pkg::ST_DONE:  st_nxt = btff_pkg::ST_IDLE;
      default:            st_nxt = btff_pkg::ST_IDLE;
    endcase
  end

  // memory commands per state
  always_comb begin
    cmd = '0;
    case (st_r)
      btff_pkg::ST_INIT: begin
        cmd.we = 1'b1;
        cmd.addr = 16'(0);
        cmd.wdata = tagv(ARENA - TB2, 1'b1);
      end
      btff_pkg::ST_INIT2: begin
        cmd.we = 1'b1;
        cmd.addr = 16'(ARENA - TB);
        cmd.wdata = tagv(ARENA - TB2, 1'b1);
      end
      btff_pkg::ST_RD: cmd.addr = 16'(p_r);
      btff_pkg::ST_SPLIT_A, btff_pkg::ST_SPLIT_B: begin
        // remainder block tags when splitting
        if (sz_r - PW'(req_r.request_size) >= MINSP) begin
          cmd.we = 1'b1;
          cmd.wdata = tagv(sz_r - PW'(req_r.request_size) - TB2, 1'b1);
          cmd.addr = (st_r == btff_pkg::ST_SPLIT_A)
                     ? 16'(p_r + PW'(req_r.request_size) + TB2)
                     : 16'(p_r + sz_r + TB);
        end
      end
      btff_pkg::ST_SPLIT_C, btff_pkg::ST_SPLIT_D: begin
        cmd.we = 1'b1;
        if (sz_r - PW'(req_r.request_size) >= MINSP) begin
          cmd.wdata = tagv(PW'(req_r.request_size), 1'b0);
          cmd.addr = (st_r == btff_pkg::ST_SPLIT_C) ? 16'(p_r)
                     : 16'(p_r + TB + PW'(req_r.request_size));
        end else begin
          cmd.wdata = tagv(sz_r, 1'b0);
          cmd.addr = (st_r == btff_pkg::ST_SPLIT_C) ? 16'(p_r) : 16'(p_r + TB + sz_r);
        end
      end
      btff_pkg::ST_FREE_A: begin
        cmd.we = 1'b1; cmd.addr = 16'(p_r); cmd.wdata = tagv(sz_r, 1'b1);
      end
      btff_pkg::ST_FREE_B: begin
        cmd.we = 1'b1; cmd.addr = 16'(p_r + TB + sz_r); cmd.wdata = tagv(sz_r, 1'b1);
      end
      btff_pkg::ST_MR_RD: cmd.addr = 16'(aux_r);
      btff_pkg::ST_MR_W1, btff_pkg::ST_MR_W2: begin
        cmd.we = (st_r == btff_pkg::ST_MR_W1) || (p_r + TB + sz_r + TB <= ARENA);
        cmd.addr = (st_r == btff_pkg::ST_MR_W1) ? 16'(p_r) : 16'(p_r + TB + sz_r);
        cmd.wdata = tagv(sz_r, 1'b1);
      end
      btff_pkg::ST_ML_RD: cmd.addr = 16'(p_r - TB);
      btff_pkg::ST_ML_W1, btff_pkg::ST_ML_W2: begin
        cmd.we = (st_r == btff_pkg::ST_ML_W1) || (aux_r + TB + sz_r + TB <= ARENA);
        cmd.addr = (st_r == btff_pkg::ST_ML_W1) ? 16'(aux_r) : 16'(aux_r + TB + sz_r);
        cmd.wdata = tagv(sz_r, 1'b1);
      end
      default: cmd = '0;
    endcase
  end

  // state, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= btff_pkg::ST_INIT;
      ovalid_r <= 1'b0;
      busy_r <= '0;
      used_r <= '0;
    end else begin
      st_r <= st_nxt;
      p_r <= p_nxt;
      sz_r <= sz_nxt;
      aux_r <= aux_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      if (in_fire) begin
        req_r <= in_ch.data;
        rsp_r <= '0;
        largest_r <= '0;
      end
      // track the largest free block on info walks
      if (st_r == btff_pkg::ST_EVAL && req_r.kind == btff_pkg::KIND_INFO &&
          tnext <= ARENA && tfree && 13'(tsize) > largest_r) begin
        largest_r <= 13'(tsize);
      end
      if (st_r == btff_pkg::ST_SPLIT_D) begin
        busy_r <= busy_r + 11'd1;
        used_r <= used_r + ((sz_r - PW'(req_r.request_size) >= MINSP)
                  ? 13'(req_r.request_size) : 13'(sz_r));
        rsp_r.ok <= 1'b1;
        rsp_r.granted_address <= 12'(p_r + TB);
      end
      if (st_r == btff_pkg::ST_FREE_A) begin
        busy_r <= busy_r - 11'd1;
        used_r <= used_r - 13'(sz_r);
        rsp_r.ok <= 1'b1;
      end
      if (st_r == btff_pkg::ST_DONE) begin
        ovalid_r <= 1'b1;
        if (req_r.kind == btff_pkg::KIND_INFO) begin
          rsp_r.ok <= 1'b1;
          rsp_r.busy_blocks <= busy_r;
          rsp_r.bytes_in_use <= used_r;
          rsp_r.largest_free <= largest_r;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // no new item while a result is pending
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_ch.ready) else $error("item taken with result pending");
  // a result appears only after the done step
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(st_r) == btff_pkg::ST_DONE)
    else $error("result without done step");
  // the tag memory is never written while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == btff_pkg::ST_IDLE |-> !cmd.we) else $error("write while idle");
`endif
endmodule
`default_nettype wire
